// File: hdl/tcgr_pkg.sv
// ----------------------------------------------------------------------------
// tcgr_pkg
// shared types, codes and the color palette of the text cell glyph renderer
// ----------------------------------------------------------------------------
package tcgr_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned PIX_W      = 24;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned PITCH_W    = 16;
  localparam int unsigned CELL_W     = 10;
  localparam int unsigned NUM_PIX    = 8;

  // transaction opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_ADDRESS = 2'd0,
    REG_LINE_PITCH   = 2'd1,
    REG_TEXT_COLUMNS = 2'd2,
    REG_TEXT_ROWS    = 2'd3
  } cfg_reg_e;

  // fixed 16-entry palette, 0xRRGGBB
  localparam logic [PIX_W-1:0] PALETTE [16] = '{
    24'h000000, 24'h1E66F5, 24'h20A020, 24'h179299,
    24'hC02020, 24'h8839EF, 24'hB07020, 24'hC0C0C0,
    24'h555555, 24'h4080FF, 24'h40D040, 24'h40D0E0,
    24'hFF4040, 24'hE040FF, 24'hFFE040, 24'hFFFFFF
  };

  // controller to datapath
  typedef struct packed {
    logic clr_wr;
    logic load_wr;
    logic draw_cap;
    logic mul_en;
    logic addr_en;
    logic run_en;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic draw_ok;
    logic run_done;
  } status_t;

endpackage

// File: hdl/tcgr_ctrl.sv
// ----------------------------------------------------------------------------
// tcgr_ctrl
// sequencer: font clear after reset, transaction accept and glyph row run
// ----------------------------------------------------------------------------
module tcgr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             op_i,
  input  tcgr_pkg::status_t status_i,
  output tcgr_pkg::cmd_t   cmd_o,
  output logic             busy
);
  import tcgr_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_MUL   = 5'b00100,
    ST_ADDR  = 5'b01000,
    ST_RUN   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign accept = start && (state_q == ST_IDLE);

  always_comb begin
    cmd_o          = '0;
    cmd_o.clr_wr   = (state_q == ST_CLEAR);
    cmd_o.load_wr  = accept && (op_i == OP_LOAD);
    cmd_o.draw_cap = accept && (op_i == OP_DRAW) && status_i.draw_ok;
    cmd_o.mul_en   = (state_q == ST_MUL);
    cmd_o.addr_en  = (state_q == ST_ADDR);
    cmd_o.run_en   = (state_q == ST_RUN);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (status_i.clr_done) state_d = ST_IDLE;
      ST_IDLE:  if (cmd_o.draw_cap) state_d = ST_MUL;
      ST_MUL:   state_d = ST_ADDR;
      ST_ADDR:  state_d = ST_RUN;
      ST_RUN:   if (status_i.run_done) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

// File: hdl/tcgr_datapath.sv
// ----------------------------------------------------------------------------
// tcgr_datapath
// config registers, font memory, address arithmetic and pixel expansion
// ----------------------------------------------------------------------------
module tcgr_datapath #(
  parameter int unsigned GLYPH_HEIGHT = 16,
  parameter int unsigned GLYPH_COUNT  = 256
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  tcgr_pkg::cmd_t                           cmd_i,
  output tcgr_pkg::status_t                        status_o,
  input  logic                                     cfg_we_i,
  input  logic [tcgr_pkg::CFG_IDX_W-1:0]           cfg_idx_i,
  input  logic [tcgr_pkg::CFG_DATA_W-1:0]          cfg_wdata_i,
  input  logic [7:0]                               char_code_i,
  input  logic [3:0]                               glyph_line_i,
  input  logic [7:0]                               glyph_bits_i,
  input  logic signed [tcgr_pkg::CELL_W-1:0]       cell_column_i,
  input  logic signed [tcgr_pkg::CELL_W-1:0]       cell_row_i,
  input  logic [7:0]                               attribute_i,
  output logic                                     result_strobe_o,
  output logic [tcgr_pkg::ADDR_W-1:0]              row_address_o,
  output logic [tcgr_pkg::PIX_W-1:0]               pixel_o [tcgr_pkg::NUM_PIX],
  output logic                                     last_row_o
);
  import tcgr_pkg::*;

  localparam int unsigned DEPTH  = GLYPH_COUNT * GLYPH_HEIGHT;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned LINE_W = $clog2(256 * GLYPH_HEIGHT);
  localparam int unsigned PROD_W = LINE_W + PITCH_W;
  localparam int unsigned CW     = $clog2(GLYPH_HEIGHT + 1);

  // configuration registers
  logic [ADDR_W-1:0]  base_q;
  logic [PITCH_W-1:0] pitch_q;
  logic [7:0]         cols_q;
  logic [7:0]         rows_q;

  // per cell context
  logic [LINE_W-1:0]  line0_q;
  logic [7:0]         col_q;
  logic [AW-1:0]      gbase_q;
  logic               blank_q;
  logic [PIX_W-1:0]   fg_q;
  logic [PIX_W-1:0]   bg_q;
  logic [PROD_W-1:0]  prod_q;
  logic [ADDR_W-1:0]  row_addr_q;
  logic [CW-1:0]      cnt_q;

  // font memory
  logic [7:0]         font_mem [DEPTH];
  logic [7:0]         rdata_q;
  logic [AW-1:0]      clr_cnt_q;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [7:0]         mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic               load_ok;
  logic [7:0]         bits;

  // output stage
  logic               strobe_q;
  logic [ADDR_W-1:0]  out_addr_q;
  logic [PIX_W-1:0]   pix_q [NUM_PIX];
  logic               last_q;

  // range checks on the incoming cell
  logic col_ok;
  logic row_ok;
  assign col_ok = !cell_column_i[CELL_W-1] && !cell_column_i[CELL_W-2]
                  && (cell_column_i[7:0] < cols_q);
  assign row_ok = !cell_row_i[CELL_W-1] && !cell_row_i[CELL_W-2]
                  && (cell_row_i[7:0] < rows_q);

  always_comb begin
    status_o          = '0;
    status_o.clr_done = (clr_cnt_q == AW'(DEPTH - 1));
    status_o.draw_ok  = (base_q != '0) && col_ok && row_ok;
    status_o.run_done = (cnt_q == CW'(GLYPH_HEIGHT));
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      pitch_q <= PITCH_W'(4096);
      cols_q  <= 8'd128;
      rows_q  <= 8'd48;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_BASE_ADDRESS: base_q  <= cfg_wdata_i;
        REG_LINE_PITCH:   pitch_q <= cfg_wdata_i[PITCH_W-1:0];
        REG_TEXT_COLUMNS: cols_q  <= cfg_wdata_i[7:0];
        REG_TEXT_ROWS:    rows_q  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // font memory write port: clearing sweep or glyph row load
  assign load_ok = ({1'b0, char_code_i} < 9'(GLYPH_COUNT))
                   && (32'(glyph_line_i) < GLYPH_HEIGHT);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_cnt_q;
    mem_wdata = '0;
    if (cmd_i.clr_wr) begin
      mem_we = 1'b1;
    end else if (cmd_i.load_wr && load_ok) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(char_code_i) * AW'(GLYPH_HEIGHT) + AW'(glyph_line_i);
      mem_wdata = glyph_bits_i;
    end
  end

  assign mem_re    = (cmd_i.addr_en || cmd_i.run_en) && (cnt_q < CW'(GLYPH_HEIGHT));
  assign mem_raddr = gbase_q + AW'(cnt_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      font_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= font_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_wr && !status_o.clr_done) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  // cell capture, line offset multiply, start address
  always_ff @(posedge clk_i) begin
    if (cmd_i.draw_cap) begin
      line0_q <= LINE_W'(cell_row_i[7:0]) * LINE_W'(GLYPH_HEIGHT);
      col_q   <= cell_column_i[7:0];
      gbase_q <= AW'(char_code_i) * AW'(GLYPH_HEIGHT);
      blank_q <= ({1'b0, char_code_i} >= 9'(GLYPH_COUNT));
      fg_q    <= PALETTE[attribute_i[3:0]];
      bg_q    <= PALETTE[attribute_i[7:4]];
    end
    if (cmd_i.mul_en) begin
      prod_q <= PROD_W'(line0_q) * PROD_W'(pitch_q);
    end
    if (cmd_i.addr_en) begin
      row_addr_q <= base_q + ADDR_W'(prod_q) + {19'd0, col_q, 5'd0};
    end else if (cmd_i.run_en) begin
      row_addr_q <= row_addr_q + ADDR_W'(pitch_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.draw_cap) begin
      cnt_q <= '0;
    end else if (cmd_i.addr_en || cmd_i.run_en) begin
      cnt_q <= cnt_q + CW'(1);
    end
  end

  // pixel expansion, msb of the glyph row first
  assign bits = blank_q ? 8'd0 : rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.run_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.run_en) begin
      out_addr_q <= row_addr_q;
      last_q     <= status_o.run_done;
      for (int p = 0; p < NUM_PIX; p++) begin
        pix_q[p] <= bits[NUM_PIX-1-p] ? fg_q : bg_q;
      end
    end
  end

  assign result_strobe_o = strobe_q;
  assign row_address_o   = out_addr_q;
  assign pixel_o         = pix_q;
  assign last_row_o      = last_q;

endmodule

// File: hdl/text_cell_glyph_renderer.sv
// ----------------------------------------------------------------------------
// text_cell_glyph_renderer
// turns character cells into glyph row pixel writes for a 32 bpp framebuffer
// ----------------------------------------------------------------------------
//  channel   | ports                                         | direction
//  ----------+-----------------------------------------------+----------
//  command   | start, busy, op_i, char_code_i, glyph_line_i, | in
//            | glyph_bits_i, cell_column_i, cell_row_i,      |
//            | attribute_i                                   |
//  config    | cfg_we_i, cfg_idx_i, cfg_wdata_i              | in
//  result    | result_strobe_o, row_address_o, pixel_0_o ..  | out
//            | pixel_7_o, last_row_o                         |
//
//  a command transaction is taken at a clock edge with start high and busy low
//  busy stays low for a load
//  a draw holds busy through the line offset multiply, the start address and
//    the glyph row run, one glyph row per cycle, set by the single read port of
//    the font memory
//  results leave one per cycle, registered from the glyph row run states; the
//    receiver cannot stall, each result is valid for the one strobe cycle
//  after reset the font memory is cleared one entry per cycle, all
//    GLYPH_COUNT * GLYPH_HEIGHT entries (4096 by default), with busy high
// ----------------------------------------------------------------------------
module text_cell_glyph_renderer #(
  parameter int unsigned GLYPH_HEIGHT = 16,
  parameter int unsigned GLYPH_COUNT  = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic                                op_i,
  input  logic [7:0]                          char_code_i,
  input  logic [3:0]                          glyph_line_i,
  input  logic [7:0]                          glyph_bits_i,
  input  logic signed [tcgr_pkg::CELL_W-1:0]  cell_column_i,
  input  logic signed [tcgr_pkg::CELL_W-1:0]  cell_row_i,
  input  logic [7:0]                          attribute_i,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [tcgr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tcgr_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // result channel
  output logic                                result_strobe_o,
  output logic [tcgr_pkg::ADDR_W-1:0]         row_address_o,
  output logic [tcgr_pkg::PIX_W-1:0]          pixel_0_o,
  output logic [tcgr_pkg::PIX_W-1:0]          pixel_1_o,
  output logic [tcgr_pkg::PIX_W-1:0]          pixel_2_o,
  output logic [tcgr_pkg::PIX_W-1:0]          pixel_3_o,
  output logic [tcgr_pkg::PIX_W-1:0]          pixel_4_o,
  output logic [tcgr_pkg::PIX_W-1:0]          pixel_5_o,
  output logic [tcgr_pkg::PIX_W-1:0]          pixel_6_o,
  output logic [tcgr_pkg::PIX_W-1:0]          pixel_7_o,
  output logic                                last_row_o
);
  import tcgr_pkg::*;

  cmd_t             cmd;
  status_t          status;
  logic [PIX_W-1:0] pixel [NUM_PIX];

  // sequencer: clear sweep, accept, multiply, address, row run
  tcgr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .op_i     (op_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  // registers, font memory and per row arithmetic
  tcgr_datapath #(
    .GLYPH_HEIGHT (GLYPH_HEIGHT),
    .GLYPH_COUNT  (GLYPH_COUNT)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .char_code_i     (char_code_i),
    .glyph_line_i    (glyph_line_i),
    .glyph_bits_i    (glyph_bits_i),
    .cell_column_i   (cell_column_i),
    .cell_row_i      (cell_row_i),
    .attribute_i     (attribute_i),
    .result_strobe_o (result_strobe_o),
    .row_address_o   (row_address_o),
    .pixel_o         (pixel),
    .last_row_o      (last_row_o)
  );

  // leftmost pixel first
  assign pixel_0_o = pixel[0];
  assign pixel_1_o = pixel[1];
  assign pixel_2_o = pixel[2];
  assign pixel_3_o = pixel[3];
  assign pixel_4_o = pixel[4];
  assign pixel_5_o = pixel[5];
  assign pixel_6_o = pixel[6];
  assign pixel_7_o = pixel[7];

endmodule
